@@ rtl/sfd_pkg.sv @@
// ----------------------------------------------------------------------------
// SLIP frame decoder package
// Shared constants, codes and types for the SLIP frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

  // Line codes of the byte stuffing scheme.
  localparam logic [7:0] SLIP_END     = 8'hC0;
  localparam logic [7:0] SLIP_ESC     = 8'hDB;
  localparam logic [7:0] SLIP_ESC_END = 8'hDC;
  localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;
  localparam logic [7:0] SLIP_ESC_ZER = 8'hDE;
  localparam logic [7:0] ZERO_BYTE    = 8'h00;

  // IPv4 check on the first decoded byte of a frame.
  localparam logic [7:0] NIBBLE_MASK  = 8'hF0;
  localparam logic [7:0] IPV4_NIBBLE  = 8'h40;

  // Field widths.
  localparam int LEN_W     = 12;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 12;
  localparam int OUT_W     = 24;

  // Register reset values.
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 12'd1500;
  localparam logic [7:0]       MIN_LEN_RESET = 8'd20;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_ZERO_EN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN     = 2'd2;

  // Input kinds.
  localparam logic MODE_BYTE  = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // Result kinds.
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Frame status codes.
  localparam logic [STATUS_W-1:0] STATUS_GOOD     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SHORT    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_IPV4 = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_OVERSIZE = 2'd3;

  typedef struct packed {
    logic                kind;
    logic [7:0]          data_byte;
    logic [STATUS_W-1:0] frame_status;
    logic [LEN_W-1:0]    frame_length;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/slip_frame_decoder_top.sv @@
// ----------------------------------------------------------------------------
// SLIP frame decoder
// Removes SLIP byte stuffing from a line byte stream and reports frame ends.
// ----------------------------------------------------------------------------
// The decoder takes one line byte or flush command per clock while s_tready is
// high and produces at most one result for it: a decoded data byte, or a
// frame-end status with the kept length. Decoder state is updated in the
// accepting cycle, so a new transaction can follow every cycle. The output
// side has a result register and one skid entry; s_tready drops only while
// the skid entry is occupied, which takes two stalled results in a row. Bytes
// before the first END after reset or a flush are discarded. Configuration
// must be written only while idle; the block itself does not enforce it.
`default_nettype none

module slip_frame_decoder_top #(
  parameter int COUNT_BITS = 12
) (
  input  wire                          clk,
  input  wire                          rst,
  // Line side
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire  [7:0]                   s_tdata,   // [7:0] byte_in
  input  wire                          s_tuser,   // [0] mode
  // Result side
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [sfd_pkg::OUT_W-1:0]    m_tdata,   // [7:0] data_byte,
                                                  // [9:8] frame_status,
                                                  // [21:10] frame_length,
                                                  // [23:22] zero
  output logic                         m_tuser,   // [0] kind
  // Configuration
  input  wire                          cfg_we,
  input  wire  [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [sfd_pkg::CFG_W-1:0]    cfg_data
);

  import sfd_pkg::*;

  localparam int CMP_W = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;
  localparam logic [COUNT_BITS-1:0] COUNT_FULL = {COUNT_BITS{1'b1}};

  // Configuration registers
  logic             escape_zero_enable;
  logic [LEN_W-1:0] max_frame_len;
  logic [7:0]       min_frame_len;

  // Decoder state
  logic                  synced, synced_next;
  logic                  escaping, escaping_next;
  logic                  overflowed, overflowed_next;
  logic [COUNT_BITS-1:0] byte_count, byte_count_next;
  logic [7:0]            first_byte, first_byte_next;

  // Output register and skid entry
  logic    out_valid;
  result_t out_res;
  logic    skid_valid;
  result_t skid_res;

  logic    in_fire;
  logic    res_valid;
  result_t res;
  logic [7:0]          dec_byte;
  logic                full;
  logic [STATUS_W-1:0] status;

  assign in_fire  = s_tvalid && s_tready;
  assign s_tready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_zero_enable <= 1'b0;
      max_frame_len      <= MAX_LEN_RESET;
      min_frame_len      <= MIN_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ESC_ZERO_EN: escape_zero_enable <= cfg_data[0];
        CFG_MAX_LEN:     max_frame_len      <= cfg_data[LEN_W-1:0];
        CFG_MIN_LEN:     min_frame_len      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Unstuffing of the byte that follows an escape.
  always_comb begin
    dec_byte = s_tdata;
    if (escaping) begin
      priority if (s_tdata == SLIP_ESC_END) begin
        dec_byte = SLIP_END;
      end else if (s_tdata == SLIP_ESC_ESC) begin
        dec_byte = SLIP_ESC;
      end else if (s_tdata == SLIP_ESC_ZER && escape_zero_enable) begin
        dec_byte = ZERO_BYTE;
      end else begin
        // An unknown escape passes the byte through unchanged.
        dec_byte = s_tdata;
      end
    end
  end

  assign full = (CMP_W'(byte_count) >= CMP_W'(max_frame_len)) ||
                (byte_count == COUNT_FULL);

  always_comb begin
    priority if (overflowed) begin
      status = STATUS_OVERSIZE;
    end else if (CMP_W'(byte_count) < CMP_W'(min_frame_len)) begin
      status = STATUS_SHORT;
    end else if ((first_byte & NIBBLE_MASK) != IPV4_NIBBLE) begin
      status = STATUS_NOT_IPV4;
    end else begin
      status = STATUS_GOOD;
    end
  end

  always_comb begin
    synced_next     = synced;
    escaping_next   = escaping;
    overflowed_next = overflowed;
    byte_count_next = byte_count;
    first_byte_next = first_byte;
    res_valid       = 1'b0;
    res             = '0;
    priority if (s_tuser == MODE_FLUSH) begin
      synced_next     = 1'b0;
      escaping_next   = 1'b0;
      overflowed_next = 1'b0;
      byte_count_next = '0;
      first_byte_next = '0;
    end else if (!synced) begin
      synced_next = (s_tdata == SLIP_END);
    end else if (s_tdata == SLIP_END) begin
      escaping_next   = 1'b0;
      overflowed_next = 1'b0;
      byte_count_next = '0;
      first_byte_next = '0;
      if (byte_count != '0 || overflowed) begin
        res_valid        = 1'b1;
        res.kind         = KIND_END;
        res.frame_status = status;
        res.frame_length = LEN_W'(byte_count);
      end
    end else if (s_tdata == SLIP_ESC) begin
      escaping_next = 1'b1;
    end else begin
      escaping_next = 1'b0;
      if (full) begin
        overflowed_next = 1'b1;
      end else begin
        if (byte_count == '0) begin
          first_byte_next = dec_byte;
        end
        byte_count_next = byte_count + 1'b1;
        res_valid       = 1'b1;
        res.kind        = KIND_DATA;
        res.data_byte   = dec_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      synced     <= 1'b0;
      escaping   <= 1'b0;
      overflowed <= 1'b0;
      byte_count <= '0;
      first_byte <= '0;
    end else if (in_fire) begin
      synced     <= synced_next;
      escaping   <= escaping_next;
      overflowed <= overflowed_next;
      byte_count <= byte_count_next;
      first_byte <= first_byte_next;
    end
  end

  // A new result goes to the output register when it is free or being
  // drained, otherwise it parks in the skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || m_tready) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= in_fire && res_valid;
        end
      end else if (in_fire && res_valid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      out_res <= skid_valid ? skid_res : res;
    end
    if (out_valid && !m_tready && in_fire && res_valid) begin
      skid_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.kind;
  assign m_tdata  = {2'b00, out_res.frame_length, out_res.frame_status,
                     out_res.data_byte};

  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a result while the output register is empty");

  a_end_no_data : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_END) |-> (m_tdata[7:0] == ZERO_BYTE))
    else $error("frame-end result carries a data byte");

  a_data_no_status : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_DATA) |-> (m_tdata[OUT_W-1:8] == '0))
    else $error("data result carries a status or length");

  a_unsynced_empty : assert property (@(posedge clk) disable iff (rst)
    !synced |-> (byte_count == '0 && !overflowed && !escaping))
    else $error("frame state present while out of sync");

endmodule

`default_nettype wire
